// ----- src/rtt_pkg.sv -----
// ----------------------------------------------------------------------------
// rtt_pkg
// Types and codes shared by the repeating timer table modules.
// ----------------------------------------------------------------------------
package rtt_pkg;

  localparam int TIME_W   = 48;
  localparam int ID_W     = 16;
  localparam int IV_W     = 31;
  localparam int MAX_FIRE = 16;
  localparam int FIRE_W   = 5;

  localparam logic [1:0] REQ_SCHEDULE = 2'd0;
  localparam logic [1:0] REQ_CANCEL   = 2'd1;
  localparam logic [1:0] REQ_FLUSH    = 2'd2;

  localparam logic [2:0] ST_ACCEPTED  = 3'd0;
  localparam logic [2:0] ST_BAD_ID    = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_CANCELLED = 3'd3;
  localparam logic [2:0] ST_FIRED     = 3'd4;
  localparam logic [2:0] ST_NONE_DUE  = 3'd5;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] deadline;
    logic [IV_W-1:0]   interval;
    logic              rep;
  } entry_t;

  typedef enum logic [2:0] {
    SEL_ACCEPT,
    SEL_BAD,
    SEL_FULL,
    SEL_CANCEL,
    SEL_FIRE_MID,
    SEL_FIRE_LAST,
    SEL_NONE
  } emit_sel_t;

  typedef struct packed {
    logic      load;
    logic      scan_init;
    logic      keep;
    logic      rearm;
    logic      drop;
    logic      sch_write;
    logic      sch_next;
    logic      commit;
    logic      div_start;
    logic      pend_set;
    logic      emit;
    emit_sel_t sel;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       id_zero;
    logic       at_end;
    logic       id_match;
    logic       due;
    logic       is_repeat;
    logic       iv_zero;
    logic       full;
    logic       div_busy;
    logic       out_free;
    logic       pend;
  } sts_t;

endpackage

// ----- src/rtt_datapath.sv -----
// ----------------------------------------------------------------------------
// rtt_datapath
// Timer store, scan pointers, remainder unit and result register.
// ----------------------------------------------------------------------------
module rtt_datapath import rtt_pkg::*; #(
  parameter int TIMER_SLOTS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  cmd_t          cmd,
  output sts_t          sts,
  input  logic [1:0]    in_type,
  input  logic [15:0]   in_id,
  input  logic [31:0]   in_delay,
  input  logic          in_rep,
  input  logic [47:0]   in_now,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [15:0]   out_id,
  output logic [2:0]    out_status,
  output logic          out_last
);

  localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CW = $clog2(TIMER_SLOTS + 1);
  localparam logic [CW-1:0] SLOTS_C = CW'(TIMER_SLOTS);
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  entry_t mem [TIMER_SLOTS];
  entry_t rdata;

  logic [1:0]        req_type;
  logic [ID_W-1:0]   req_id;
  logic [IV_W-1:0]   req_delay;
  logic              req_rep;
  logic [TIME_W-1:0] req_now;

  logic [CW-1:0]     rd, wr, count;
  logic [FIRE_W-1:0] fired;
  logic              pend, hit;
  logic [ID_W-1:0]   pend_id;

  logic [IV_W-1:0]   rem;
  logic [TIME_W-1:0] dividend;
  logic [5:0]        div_cnt;
  logic              div_busy;
  logic [IV_W:0]     trial;

  logic [TIME_W:0]   sch_sum, rearm_sum;
  logic [TIME_W-1:0] sch_dl, rearm_dl;
  entry_t            wdata;
  logic              we;
  logic [IW-1:0]     waddr;

  assign sch_sum = {1'b0, req_now} + {{(TIME_W-IV_W+1){1'b0}}, req_delay};
  assign sch_dl  = sch_sum[TIME_W] ? TIME_MAX : sch_sum[TIME_W-1:0];

  always_comb begin
    if (rdata.interval == '0) begin
      rearm_sum = {1'b0, req_now} + {{TIME_W{1'b0}}, 1'b1};
    end else begin
      rearm_sum = {1'b0, req_now} - {{(TIME_W-IV_W+1){1'b0}}, rem}
                  + {{(TIME_W-IV_W+1){1'b0}}, rdata.interval};
    end
  end
  assign rearm_dl = rearm_sum[TIME_W] ? TIME_MAX : rearm_sum[TIME_W-1:0];

  assign trial = {rem, dividend[TIME_W-1]};

  always_comb begin
    we    = 1'b0;
    waddr = wr[IW-1:0];
    wdata = rdata;
    if (cmd.sch_write) begin
      we    = 1'b1;
      waddr = rd[IW-1:0];
      wdata = '{id: req_id, deadline: sch_dl, interval: req_delay, rep: req_rep};
    end else if (cmd.keep) begin
      we = 1'b1;
      if (cmd.rearm) wdata.deadline = rearm_dl;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[rd[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_type  <= in_type;
      req_id    <= in_id;
      req_delay <= in_delay[31] ? '0 : in_delay[30:0];
      req_rep   <= in_rep;
      req_now   <= in_now;
    end
    if (cmd.pend_set) pend_id <= rdata.id;
    if (cmd.div_start) begin
      rem      <= '0;
      dividend <= req_now - rdata.deadline;
    end else if (div_busy) begin
      rem      <= (trial >= {1'b0, rdata.interval}) ?
                  IV_W'(trial - {1'b0, rdata.interval}) : trial[IV_W-1:0];
      dividend <= {dividend[TIME_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd <= '0; wr <= '0; count <= '0; fired <= '0;
      pend <= 1'b0; hit <= 1'b0;
      div_busy <= 1'b0; div_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.scan_init) begin
        rd <= '0; wr <= '0; fired <= '0; pend <= 1'b0; hit <= 1'b0;
      end
      if (cmd.keep) begin
        rd <= rd + 1'b1;
        wr <= wr + 1'b1;
      end
      if (cmd.drop) begin
        rd  <= rd + 1'b1;
        hit <= 1'b1;
      end
      if (cmd.sch_next) rd <= rd + 1'b1;
      if (cmd.sch_write && rd == count) count <= count + 1'b1;
      if (cmd.commit) count <= wr;
      if (cmd.pend_set) begin
        pend  <= 1'b1;
        fired <= fired + 1'b1;
      end
      if (cmd.div_start) begin
        div_busy <= 1'b1;
        div_cnt  <= 6'(TIME_W);
      end else if (div_busy) begin
        div_cnt  <= div_cnt - 1'b1;
        div_busy <= div_cnt != 6'd1;
      end
      if (cmd.emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      unique case (cmd.sel)
        SEL_ACCEPT:    begin out_id <= req_id; out_status <= ST_ACCEPTED;  out_last <= 1'b1; end
        SEL_BAD:       begin out_id <= '0;     out_status <= ST_BAD_ID;    out_last <= 1'b1; end
        SEL_FULL:      begin out_id <= '0;     out_status <= ST_FULL;      out_last <= 1'b1; end
        SEL_CANCEL:    begin
          out_id <= hit ? req_id : '0; out_status <= ST_CANCELLED; out_last <= 1'b1;
        end
        SEL_FIRE_MID:  begin out_id <= pend_id; out_status <= ST_FIRED;    out_last <= 1'b0; end
        SEL_FIRE_LAST: begin out_id <= pend_id; out_status <= ST_FIRED;    out_last <= 1'b1; end
        SEL_NONE:      begin out_id <= '0;     out_status <= ST_NONE_DUE;  out_last <= 1'b1; end
        default:       begin out_id <= '0;     out_status <= ST_NONE_DUE;  out_last <= 1'b1; end
      endcase
    end
  end

  always_comb begin
    sts.req_type  = req_type;
    sts.id_zero   = req_id == '0;
    sts.at_end    = rd == count;
    sts.id_match  = rdata.id == req_id;
    sts.due       = (rdata.deadline <= req_now) && (fired < FIRE_W'(MAX_FIRE));
    sts.is_repeat = rdata.rep;
    sts.iv_zero   = rdata.interval == '0;
    sts.full      = count == SLOTS_C;
    sts.div_busy  = div_busy;
    sts.out_free  = !out_valid || out_ready;
    sts.pend      = pend;
  end

endmodule

// ----- src/rtt_control.sv -----
// ----------------------------------------------------------------------------
// rtt_control
// Request sequencer: dispatches, walks the table and issues results.
// ----------------------------------------------------------------------------
module rtt_control import rtt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    IDLE, DISPATCH, S_RD, S_EV, C_RD, C_EV, F_RD, F_EV, F_DIV, EMIT
  } state_t;

  state_t    state, state_next;
  emit_sel_t sel, sel_next;

  assign in_ready = state == IDLE;

  always_comb begin
    cmd        = '0;
    cmd.sel    = sel;
    state_next = state;
    sel_next   = sel;
    unique case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = DISPATCH;
        end
      end
      DISPATCH: begin
        priority case (sts.req_type)
          REQ_SCHEDULE: begin
            if (sts.id_zero) begin
              sel_next   = SEL_BAD;
              state_next = EMIT;
            end else begin
              cmd.scan_init = 1'b1;
              state_next    = S_RD;
            end
          end
          REQ_CANCEL: begin cmd.scan_init = 1'b1; state_next = C_RD; end
          REQ_FLUSH:  begin cmd.scan_init = 1'b1; state_next = F_RD; end
          default:    state_next = IDLE;
        endcase
      end
      S_RD: state_next = S_EV;
      S_EV: begin
        if (sts.at_end && sts.full) begin
          sel_next   = SEL_FULL;
          state_next = EMIT;
        end else if (sts.at_end || sts.id_match) begin
          cmd.sch_write = 1'b1;
          sel_next      = SEL_ACCEPT;
          state_next    = EMIT;
        end else begin
          cmd.sch_next = 1'b1;
          state_next   = S_RD;
        end
      end
      C_RD: state_next = C_EV;
      C_EV: begin
        if (sts.at_end) begin
          cmd.commit = 1'b1;
          sel_next   = SEL_CANCEL;
          state_next = EMIT;
        end else begin
          if (sts.id_match && !sts.id_zero) cmd.drop = 1'b1;
          else cmd.keep = 1'b1;
          state_next = C_RD;
        end
      end
      F_RD: state_next = F_EV;
      F_EV: begin
        if (sts.at_end) begin
          cmd.commit = 1'b1;
          sel_next   = sts.pend ? SEL_FIRE_LAST : SEL_NONE;
          state_next = EMIT;
        end else if (!sts.due) begin
          cmd.keep   = 1'b1;
          state_next = F_RD;
        end else if (!sts.pend || sts.out_free) begin
          cmd.emit     = sts.pend;
          cmd.sel      = SEL_FIRE_MID;
          cmd.pend_set = 1'b1;
          if (!sts.is_repeat) begin
            cmd.drop   = 1'b1;
            state_next = F_RD;
          end else if (sts.iv_zero) begin
            cmd.keep   = 1'b1;
            cmd.rearm  = 1'b1;
            state_next = F_RD;
          end else begin
            cmd.div_start = 1'b1;
            state_next    = F_DIV;
          end
        end
      end
      F_DIV: begin
        if (!sts.div_busy) begin
          cmd.keep   = 1'b1;
          cmd.rearm  = 1'b1;
          state_next = F_RD;
        end
      end
      EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      sel   <= SEL_NONE;
    end else begin
      state <= state_next;
      sel   <= sel_next;
    end
  end

endmodule

// ----- src/repeating_timer_table.sv -----
// Time to the result grows with each entry a schedule passes over and each entry
// a cancel or flush walks; a flush also waits on the serial remainder unit for
// each due repeating timer with a non-zero interval, and on result stalls.
// One request at a time; the result register lets the next request in while
// a result waits. Synchronous reset empties the table; entry data is not cleared.
// ----------------------------------------------------------------------------
// repeating_timer_table
// Insertion-ordered table of one-shot and periodic timers.
// ----------------------------------------------------------------------------
module repeating_timer_table import rtt_pkg::*; #(
  parameter int TIMER_SLOTS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [103:0] s_axis_tdata,  // timer_id[15:0], delay[47:16], repeat_flag[48], now_ms[96:49]
  input  logic [1:0]   s_axis_tuser,  // req_type[1:0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [15:0]  m_axis_tdata,  // out_id[15:0]
  output logic [2:0]   m_axis_tuser,  // status[2:0]
  output logic         m_axis_tlast
);

  cmd_t cmd;
  sts_t sts;

  rtt_control u_control (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rtt_datapath #(.TIMER_SLOTS(TIMER_SLOTS)) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_type    (s_axis_tuser),
    .in_id      (s_axis_tdata[15:0]),
    .in_delay   (s_axis_tdata[47:16]),
    .in_rep     (s_axis_tdata[48]),
    .in_now     (s_axis_tdata[96:49]),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_id     (m_axis_tdata),
    .out_status (m_axis_tuser),
    .out_last   (m_axis_tlast)
  );

endmodule

// ----- src/rtt_checker.sv -----
// ----------------------------------------------------------------------------
// rtt_checker
// Port-level checks on the timer table results.
// ----------------------------------------------------------------------------
module rtt_checker import rtt_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  a_zero_id: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == ST_BAD_ID || m_axis_tuser == ST_FULL
      || m_axis_tuser == ST_NONE_DUE) |-> m_axis_tdata == '0 && m_axis_tlast)
    else $error("reject or none-due result malformed");

  a_accept: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == ST_ACCEPTED |-> m_axis_tdata != '0 && m_axis_tlast)
    else $error("accepted result malformed");

  a_fired_id: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == ST_FIRED |-> m_axis_tdata != '0)
    else $error("fired timer without id");

endmodule

bind repeating_timer_table rtt_checker u_rtt_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
